// File: rtl/core/data_abort_load_store_decoder_core_defines.svh
// ----------------------------------------------------------------------------
// Data abort decoder assertion macros
// Shared property wrappers for the checker of the data abort decoder core.
// ----------------------------------------------------------------------------
`ifndef DATA_ABORT_LOAD_STORE_DECODER_CORE_DEFINES_SVH
`define DATA_ABORT_LOAD_STORE_DECODER_CORE_DEFINES_SVH

// Check a property outside of reset.
`define DALS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property at every edge, reset included.
`define DALS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: rtl/core/dals_pkg.sv
// ----------------------------------------------------------------------------
// Data abort decoder package
// Beat layouts, status codes and instruction patterns of the decoder.
// ----------------------------------------------------------------------------
package dals_pkg;

  localparam int unsigned InTdataW  = 192;
  localparam int unsigned OutTdataW = 160;

  // Result status
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NOT_EMUL   = 2'd1,
    ST_UNSUP      = 2'd2,
    ST_FETCH_FAIL = 2'd3
  } status_e;

  // Opcode patterns of the write-back load/store forms
  localparam logic [31:0] PatMask       = 32'h3FE0_0C00;
  localparam logic [31:0] PatLdrPost    = 32'h3840_0400;
  localparam logic [31:0] PatLdrsPost   = 32'h3880_0400;
  localparam logic [31:0] PatLdrsPostW  = 32'h38C0_0400;
  localparam logic [31:0] PatLdrWb      = 32'h3840_0C00;
  localparam logic [31:0] PatLdrsWb     = 32'h3880_0C00;
  localparam logic [31:0] PatLdrsWbW    = 32'h38C0_0C00;
  localparam logic [31:0] PatStrPost    = 32'h3800_0400;
  localparam logic [31:0] PatStrWb      = 32'h3800_0C00;

  // Access flag fault status codes
  localparam logic [5:0] DfscAfLo = 6'd9;
  localparam logic [5:0] DfscAfHi = 6'd11;

  // Input beat, first field in the lowest bits
  typedef struct packed {
    logic [4:0]  pad;
    logic        guest_aarch64;
    logic        pc_fetch_ok;
    logic [31:0] insn_word;
    logic [63:0] fault_page;
    logic [63:0] fault_va;
    logic [24:0] syndrome;
  } in_beat_t;

  // Result beat, first field in the lowest bits; offset is two's complement
  typedef struct packed {
    logic [3:0]  pad;
    logic [63:0] ipa_out;
    logic [63:0] va_out;
    logic        write_back;
    logic        post_index;
    logic        narrow_dest;
    logic        sign_extend;
    logic [8:0]  offset;
    logic [4:0]  base_reg;
    logic [4:0]  data_reg;
    logic [1:0]  size_log2;
    logic        is_store;
    status_e     status;
  } out_beat_t;

endpackage

// File: rtl/core/data_abort_load_store_decoder_core.sv
// ----------------------------------------------------------------------------
// Data abort load/store decoder core
// Path: an accepted input beat goes into the input register, is decoded, and
//   its result beat is captured in the result register.
// Throughput: one beat per cycle while m_axis_tready_i does not stall; set by
//   the single decode stage between the input register and the result register.
// Reset: rst_ni clears both valid flags asynchronously; payload is not reset.
// ----------------------------------------------------------------------------
module data_abort_load_store_decoder_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // syndrome[24:0] fault_va[88:25] fault_page[152:89] insn_word[184:153]
  // pc_fetch_ok[185] guest_aarch64[186] zero[191:187]
  input  logic [dals_pkg::InTdataW-1:0]  s_axis_tdata_i,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // status[1:0] is_store[2] size_log2[4:3] data_reg[9:5] base_reg[14:10]
  // offset[23:15] sign_extend[24] narrow_dest[25] post_index[26]
  // write_back[27] va_out[91:28] ipa_out[155:92] zero[159:156]
  output logic [dals_pkg::OutTdataW-1:0] m_axis_tdata_o,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i
);

  dals_pkg::in_beat_t  in_q;
  logic                in_vld_q;
  dals_pkg::out_beat_t res_d, res_q;
  logic                res_vld_q;

  logic adv_res;
  logic adv_in;

  // Advance the result register when it is empty or being drained; the input
  // register moves whenever it can hand its beat on.
  assign adv_res         = !res_vld_q || m_axis_tready_i;
  assign adv_in          = !in_vld_q || adv_res;
  assign s_axis_tready_o = adv_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      if (adv_in) begin
        in_vld_q <= s_axis_tvalid_i;
      end
      if (adv_res) begin
        res_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_in && s_axis_tvalid_i) begin
      in_q <= dals_pkg::in_beat_t'(s_axis_tdata_i);
    end
    if (adv_res && in_vld_q) begin
      res_q <= res_d;
    end
  end

  // Syndrome fields
  logic       isv, sse, sf, wnr;
  logic [1:0] sas;
  logic [4:0] srt;
  logic [5:0] dfsc;
  logic       emulatable;

  assign isv  = in_q.syndrome[24];
  assign sas  = in_q.syndrome[23:22];
  assign sse  = in_q.syndrome[21];
  assign srt  = in_q.syndrome[20:16];
  assign sf   = in_q.syndrome[15];
  assign wnr  = in_q.syndrome[6];
  assign dfsc = in_q.syndrome[5:0];

  // Only a clean access flag fault (no EA, CM or S1PTW) can be emulated.
  assign emulatable = (in_q.syndrome[9:7] == 3'b000) &&
                      (dfsc >= dals_pkg::DfscAfLo) && (dfsc <= dals_pkg::DfscAfHi);

  // Instruction pattern match
  logic [31:0] pat;
  logic [1:0]  isz;
  logic        hit, m_sign, m_narrow, m_post, m_wb;

  assign pat = in_q.insn_word & dals_pkg::PatMask;
  assign isz = in_q.insn_word[31:30];

  always_comb begin
    hit      = 1'b0;
    m_sign   = 1'b0;
    m_narrow = 1'b0;
    m_post   = 1'b0;
    m_wb     = 1'b0;
    if (!wnr) begin
      unique case (pat)
        dals_pkg::PatLdrPost:   begin hit = 1'b1; m_post = 1'b1; end
        dals_pkg::PatLdrsPost:  begin hit = 1'b1; m_sign = 1'b1; m_post = 1'b1; end
        dals_pkg::PatLdrsPostW: begin
          hit = 1'b1; m_sign = 1'b1; m_narrow = 1'b1; m_post = 1'b1;
        end
        dals_pkg::PatLdrWb:     begin hit = 1'b1; m_wb = 1'b1; end
        dals_pkg::PatLdrsWb:    begin hit = 1'b1; m_sign = 1'b1; m_wb = 1'b1; end
        dals_pkg::PatLdrsWbW:   begin
          hit = 1'b1; m_sign = 1'b1; m_narrow = 1'b1; m_wb = 1'b1;
        end
        default: ;
      endcase
      // Drop the unallocated sign-extending sizes.
      if (m_sign && ((isz == 2'd3) || (m_narrow && (isz == 2'd2)))) begin
        hit = 1'b0;
      end
    end else begin
      unique case (pat)
        dals_pkg::PatStrPost: begin hit = 1'b1; m_post = 1'b1; end
        dals_pkg::PatStrWb:   begin hit = 1'b1; m_wb = 1'b1; end
        default: ;
      endcase
    end
  end

  // Result assembly
  always_comb begin
    res_d        = '0;
    res_d.status = dals_pkg::ST_OK;
    if (!emulatable) begin
      res_d.status = dals_pkg::ST_NOT_EMUL;
    end else begin
      res_d.va_out  = in_q.fault_va;
      res_d.ipa_out = {in_q.fault_page[55:0], 8'h00} | {52'd0, in_q.fault_va[11:0]};
      if (isv) begin
        res_d.is_store    = wnr;
        res_d.size_log2   = sas;
        res_d.data_reg    = srt;
        res_d.sign_extend = sse;
        res_d.narrow_dest = !sf;
      end else if (!in_q.pc_fetch_ok) begin
        res_d.status = dals_pkg::ST_FETCH_FAIL;
      end else if (!in_q.guest_aarch64 || !hit) begin
        res_d.status = dals_pkg::ST_UNSUP;
      end else begin
        res_d.is_store    = wnr;
        res_d.size_log2   = isz;
        res_d.data_reg    = in_q.insn_word[4:0];
        res_d.base_reg    = in_q.insn_word[9:5];
        res_d.offset      = in_q.insn_word[20:12];
        res_d.sign_extend = m_sign;
        res_d.narrow_dest = m_narrow;
        res_d.post_index  = m_post;
        res_d.write_back  = m_wb;
      end
    end
  end

  assign m_axis_tdata_o  = res_q;
  assign m_axis_tvalid_o = res_vld_q;

endmodule

// File: rtl/core/dals_checker.sv
// ----------------------------------------------------------------------------
// Data abort decoder checker
// Port-level properties of the decoder core, bound to the top level.
// ----------------------------------------------------------------------------
`include "data_abort_load_store_decoder_core_defines.svh"

module dals_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic [dals_pkg::OutTdataW-1:0] m_axis_tdata_o,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i
);

  dals_pkg::out_beat_t res;
  assign res = dals_pkg::out_beat_t'(m_axis_tdata_o);

  `DALS_ASSERT_ALWAYS(a_no_valid_in_reset, !rst_ni |-> !m_axis_tvalid_o, "result valid in reset")

  `DALS_ASSERT(a_hold_stalled, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o), "stalled result beat changed")

  `DALS_ASSERT(a_not_emul_zero, m_axis_tvalid_o && (res.status == dals_pkg::ST_NOT_EMUL) |-> (m_axis_tdata_o[dals_pkg::OutTdataW-1:2] == '0), "rejected abort carries data")

  `DALS_ASSERT(a_single_mode, m_axis_tvalid_o |-> !(res.post_index && res.write_back), "post index and write back both set")

  // The page bits land on bit 8 and up, so the low byte is the VA's and
  // bits 11:8 cover the VA's bits.
  `DALS_ASSERT(a_ipa_offset, m_axis_tvalid_o |-> (res.ipa_out[7:0] == res.va_out[7:0]) && ((res.ipa_out[11:8] | res.va_out[11:8]) == res.ipa_out[11:8]), "ipa page offset mismatch")

endmodule

bind data_abort_load_store_decoder_core dals_checker u_dals_checker (.*);

// File: test/data_abort_load_store_decoder_core_test.sv
// ----------------------------------------------------------------------------
// Data abort load/store decoder core testbench
// Drives syndrome/instruction beats with random idle and stall bursts, predicts
// each decoded load/store descriptor and checks every result beat in order.
// ----------------------------------------------------------------------------
module data_abort_load_store_decoder_core_test;

  // Number of random beats after the directed part, and how many of them
  // run at full rate at the end of the run.
  localparam int unsigned RandBeats  = 1850;
  localparam int unsigned FullRate   = 300;
  localparam int unsigned MaxReports = 40;

  // --------------------------------------------------------------------------
  // Scoreboard: holds the descriptors the decoder should produce, in order.
  // --------------------------------------------------------------------------
  class abort_scoreboard;
    dals_pkg::out_beat_t descr_q[$];
    int unsigned         failures;

    function new();
      failures = 0;
    endfunction

    // Compute the descriptor for one abort beat.
    function dals_pkg::out_beat_t decode_abort(dals_pkg::in_beat_t b);
      dals_pkg::out_beat_t r;
      logic [31:0] pat;
      logic [1:0]  sz;
      logic        wnr;
      logic        hit;
      logic        sgn;
      logic        nrw;
      logic        post;
      logic        wb;
      r        = '0;
      r.status = dals_pkg::ST_NOT_EMUL;
      wnr      = b.syndrome[6];
      // Only clean access flag faults can be emulated.
      if (b.syndrome[9:7] != 3'b000 || b.syndrome[5:0] < dals_pkg::DfscAfLo ||
          b.syndrome[5:0] > dals_pkg::DfscAfHi) begin
        return r;
      end
      r.va_out  = b.fault_va;
      r.ipa_out = {b.fault_page[55:0], 8'h00} | {52'd0, b.fault_va[11:0]};
      // Valid syndrome: everything comes from the ISS.
      if (b.syndrome[24]) begin
        r.status      = dals_pkg::ST_OK;
        r.is_store    = wnr;
        r.size_log2   = b.syndrome[23:22];
        r.data_reg    = b.syndrome[20:16];
        r.sign_extend = b.syndrome[21];
        r.narrow_dest = ~b.syndrome[15];
        return r;
      end
      if (!b.pc_fetch_ok) begin
        r.status = dals_pkg::ST_FETCH_FAIL;
        return r;
      end
      if (!b.guest_aarch64) begin
        r.status = dals_pkg::ST_UNSUP;
        return r;
      end
      pat  = b.insn_word & dals_pkg::PatMask;
      sz   = b.insn_word[31:30];
      hit  = 1'b0;
      sgn  = 1'b0;
      nrw  = 1'b0;
      post = 1'b0;
      wb   = 1'b0;
      if (!wnr) begin
        case (pat)
          dals_pkg::PatLdrPost: begin
            hit = 1'b1; post = 1'b1;
          end
          dals_pkg::PatLdrsPost: begin
            hit = 1'b1; sgn = 1'b1; post = 1'b1;
          end
          dals_pkg::PatLdrsPostW: begin
            hit = 1'b1; sgn = 1'b1; nrw = 1'b1; post = 1'b1;
          end
          dals_pkg::PatLdrWb: begin
            hit = 1'b1; wb = 1'b1;
          end
          dals_pkg::PatLdrsWb: begin
            hit = 1'b1; sgn = 1'b1; wb = 1'b1;
          end
          dals_pkg::PatLdrsWbW: begin
            hit = 1'b1; sgn = 1'b1; nrw = 1'b1; wb = 1'b1;
          end
          default: hit = 1'b0;
        endcase
        // Sign-extending loads of 64 bits, or of 32 bits into a W register,
        // are unallocated.
        if (hit && sgn && (sz == 2'd3 || (nrw && sz == 2'd2))) hit = 1'b0;
      end else begin
        if (pat == dals_pkg::PatStrPost) begin
          hit = 1'b1; post = 1'b1;
        end else if (pat == dals_pkg::PatStrWb) begin
          hit = 1'b1; wb = 1'b1;
        end
      end
      if (!hit) begin
        r.status = dals_pkg::ST_UNSUP;
        return r;
      end
      r.status      = dals_pkg::ST_OK;
      r.is_store    = wnr;
      r.size_log2   = sz;
      r.data_reg    = b.insn_word[4:0];
      r.base_reg    = b.insn_word[9:5];
      r.offset      = b.insn_word[20:12];
      r.sign_extend = sgn;
      r.narrow_dest = nrw;
      r.post_index  = post;
      r.write_back  = wb;
      return r;
    endfunction

    function void note_beat(dals_pkg::in_beat_t b);
      descr_q.push_back(decode_abort(b));
    endfunction

    function void field_cmp(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
        failures++;
        if (failures <= MaxReports) begin
          $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
        end
      end
    endfunction

    function void check_beat(dals_pkg::out_beat_t got);
      dals_pkg::out_beat_t want;
      if (descr_q.size() == 0) begin
        failures++;
        if (failures <= MaxReports) begin
          $display("%0t: unexpected result beat, expected none, actual %h", $time, got);
        end
        return;
      end
      want = descr_q.pop_front();
      field_cmp("status", want.status, got.status);
      field_cmp("is_store", want.is_store, got.is_store);
      field_cmp("size_log2", want.size_log2, got.size_log2);
      field_cmp("data_reg", want.data_reg, got.data_reg);
      field_cmp("base_reg", want.base_reg, got.base_reg);
      field_cmp("offset", want.offset, got.offset);
      field_cmp("sign_extend", want.sign_extend, got.sign_extend);
      field_cmp("narrow_dest", want.narrow_dest, got.narrow_dest);
      field_cmp("post_index", want.post_index, got.post_index);
      field_cmp("write_back", want.write_back, got.write_back);
      field_cmp("va_out", want.va_out, got.va_out);
      field_cmp("ipa_out", want.ipa_out, got.ipa_out);
    endfunction

    function int pending();
      return descr_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic                           clk_i           = 1'b0;
  logic                           rst_ni;
  logic [dals_pkg::InTdataW-1:0]  s_axis_tdata_i  = '0;
  logic                           s_axis_tvalid_i = 1'b0;
  logic                           s_axis_tready_o;
  logic [dals_pkg::OutTdataW-1:0] m_axis_tdata_o;
  logic                           m_axis_tvalid_o;
  logic                           m_axis_tready_i = 1'b0;

  // Idle/stall bursts are on until the full-rate tail of the run.
  logic send_idle  = 1'b1;
  logic recv_stall = 1'b1;

  abort_scoreboard abort_sb = new();

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  data_abort_load_store_decoder_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i)
  );

  // --------------------------------------------------------------------------
  // Beat builders
  // --------------------------------------------------------------------------
  // Syndrome with ISV, WnR and DFSC set, every other ISS bit clear.
  function automatic logic [24:0] mk_syn(logic isv, logic wnr, logic [5:0] dfsc);
    logic [24:0] s;
    s       = '0;
    s[24]   = isv;
    s[6]    = wnr;
    s[5:0]  = dfsc;
    return s;
  endfunction

  // Instruction word from an opcode pattern and its operand fields.
  function automatic logic [31:0] mk_word(logic [31:0] pat, logic [1:0] sz,
                                          logic [8:0] imm9, logic [4:0] rn,
                                          logic [4:0] rt);
    return pat | {sz, 30'd0} | {11'd0, imm9, 12'd0} | {22'd0, rn, 5'd0} | {27'd0, rt};
  endfunction

  function automatic dals_pkg::in_beat_t mk_beat(logic [24:0] syn, logic [31:0] word);
    dals_pkg::in_beat_t b;
    b               = '0;
    b.syndrome      = syn;
    b.fault_va      = {$urandom, $urandom};
    b.fault_page    = {$urandom, $urandom};
    b.insn_word     = word;
    b.pc_fetch_ok   = 1'b1;
    b.guest_aarch64 = 1'b1;
    return b;
  endfunction

  // Random opcode pattern; stores for WnR set, loads otherwise.
  function automatic logic [31:0] pick_pat(logic store);
    if (store) begin
      return ($urandom_range(0, 1) == 0) ? dals_pkg::PatStrPost : dals_pkg::PatStrWb;
    end
    case ($urandom_range(0, 5))
      0:       return dals_pkg::PatLdrPost;
      1:       return dals_pkg::PatLdrsPost;
      2:       return dals_pkg::PatLdrsPostW;
      3:       return dals_pkg::PatLdrWb;
      4:       return dals_pkg::PatLdrsWb;
      default: return dals_pkg::PatLdrsWbW;
    endcase
  endfunction

  // Mostly clean access flag faults with well-formed write-back words;
  // the rest is raw noise in every field.
  function automatic dals_pkg::in_beat_t random_abort();
    dals_pkg::in_beat_t b;
    logic [24:0] syn;
    logic [31:0] word;
    syn  = 25'($urandom);
    word = $urandom;
    if ($urandom_range(0, 99) >= 12) begin
      syn[9:7] = 3'b000;
      syn[5:0] = 6'($urandom_range(dals_pkg::DfscAfLo, dals_pkg::DfscAfHi));
      syn[24]  = ($urandom_range(0, 99) < 35);
      if ($urandom_range(0, 99) < 80) begin
        // Occasionally pair the pattern with the wrong transfer direction.
        word = (word & ~dals_pkg::PatMask) |
               pick_pat(($urandom_range(0, 9) == 0) ? ~syn[6] : syn[6]);
      end
    end
    b               = mk_beat(syn, word);
    b.pc_fetch_ok   = ($urandom_range(0, 9) != 0);
    b.guest_aarch64 = ($urandom_range(0, 9) != 0);
    return b;
  endfunction

  // --------------------------------------------------------------------------
  // Driver side
  // --------------------------------------------------------------------------
  // Present one beat, hold it until accepted, then note it in the scoreboard.
  task automatic send_beat(input dals_pkg::in_beat_t b);
    if (send_idle && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    s_axis_tdata_i  <= b;
    s_axis_tvalid_i <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    abort_sb.note_beat(b);
  endtask

  // Drop valid and hold off until every outstanding result has come back.
  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    while (abort_sb.pending() != 0) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Result side: stall in random bursts, check each accepted result beat.
  // --------------------------------------------------------------------------
  initial begin
    @(posedge rst_ni);
    forever begin
      if (recv_stall && $urandom_range(0, 5) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      @(posedge clk_i);
      if (m_axis_tvalid_o) abort_sb.check_beat(dals_pkg::out_beat_t'(m_axis_tdata_o));
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    dals_pkg::in_beat_t b;
    // Assert reset with a real falling edge so the async reset fires.
    rst_ni <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Not emulatable: no fault, all ISS bits set, DFSC just outside the
    // access flag range, and access flag faults with EA, CM or S1PTW.
    send_beat(mk_beat(25'd0, 32'd0));
    send_beat(mk_beat('1, '1));
    send_beat(mk_beat(mk_syn(1'b1, 1'b0, dals_pkg::DfscAfLo - 6'd1), '0));
    send_beat(mk_beat(mk_syn(1'b1, 1'b1, dals_pkg::DfscAfHi + 6'd1), '0));
    send_beat(mk_beat(mk_syn(1'b1, 1'b0, dals_pkg::DfscAfLo) | 25'h200, '0));
    send_beat(mk_beat(mk_syn(1'b1, 1'b0, dals_pkg::DfscAfLo) | 25'h100, '0));
    send_beat(mk_beat(mk_syn(1'b1, 1'b0, dals_pkg::DfscAfHi) | 25'h080, '0));

    // Valid syndrome at both ends of every ISS field, with extreme addresses.
    b            = mk_beat({1'b1, 2'd3, 1'b1, 5'd31, 1'b0, 15'd0} |
                           mk_syn(1'b1, 1'b1, dals_pkg::DfscAfHi), '0);
    b.fault_va   = '1;
    b.fault_page = '1;
    send_beat(b);
    b            = mk_beat(mk_syn(1'b1, 1'b0, dals_pkg::DfscAfLo) | 25'h8000, '1);
    b.fault_va   = '0;
    b.fault_page = '0;
    send_beat(b);

    // Fetch failed, then a guest that is not in AArch64 state.
    b             = mk_beat(mk_syn(1'b0, 1'b0, dals_pkg::DfscAfLo),
                            mk_word(dals_pkg::PatLdrPost, 2'd3, 9'h000, 5'd1, 5'd2));
    b.pc_fetch_ok = 1'b0;
    send_beat(b);
    b               = mk_beat(mk_syn(1'b0, 1'b0, dals_pkg::DfscAfLo),
                              mk_word(dals_pkg::PatLdrPost, 2'd3, 9'h000, 5'd1, 5'd2));
    b.guest_aarch64 = 1'b0;
    send_beat(b);

    // Every write-back form with legal sizes and extreme operands.
    send_beat(mk_beat(mk_syn(1'b0, 1'b0, dals_pkg::DfscAfLo),
                      mk_word(dals_pkg::PatLdrPost, 2'd3, 9'h100, 5'd31, 5'd31)));
    send_beat(mk_beat(mk_syn(1'b0, 1'b0, dals_pkg::DfscAfHi),
                      mk_word(dals_pkg::PatLdrsPost, 2'd2, 9'h0FF, 5'd0, 5'd0)));
    send_beat(mk_beat(mk_syn(1'b0, 1'b0, dals_pkg::DfscAfLo + 6'd1),
                      mk_word(dals_pkg::PatLdrsPostW, 2'd1, 9'h1FF, 5'd17, 5'd9)));
    send_beat(mk_beat(mk_syn(1'b0, 1'b0, dals_pkg::DfscAfLo),
                      mk_word(dals_pkg::PatLdrWb, 2'd0, 9'h0FF, 5'd31, 5'd0)));
    send_beat(mk_beat(mk_syn(1'b0, 1'b0, dals_pkg::DfscAfHi),
                      mk_word(dals_pkg::PatLdrsWb, 2'd0, 9'h100, 5'd0, 5'd31)));
    send_beat(mk_beat(mk_syn(1'b0, 1'b0, dals_pkg::DfscAfLo),
                      mk_word(dals_pkg::PatLdrsWbW, 2'd1, 9'h001, 5'd5, 5'd30)));
    send_beat(mk_beat(mk_syn(1'b0, 1'b1, dals_pkg::DfscAfLo),
                      mk_word(dals_pkg::PatStrPost, 2'd3, 9'h100, 5'd31, 5'd31)));
    send_beat(mk_beat(mk_syn(1'b0, 1'b1, dals_pkg::DfscAfHi),
                      mk_word(dals_pkg::PatStrWb, 2'd0, 9'h0FF, 5'd0, 5'd0)));

    // Unallocated sign-extending sizes.
    send_beat(mk_beat(mk_syn(1'b0, 1'b0, dals_pkg::DfscAfLo),
                      mk_word(dals_pkg::PatLdrsPost, 2'd3, 9'h010, 5'd3, 5'd4)));
    send_beat(mk_beat(mk_syn(1'b0, 1'b0, dals_pkg::DfscAfLo),
                      mk_word(dals_pkg::PatLdrsPostW, 2'd2, 9'h010, 5'd3, 5'd4)));
    send_beat(mk_beat(mk_syn(1'b0, 1'b0, dals_pkg::DfscAfLo),
                      mk_word(dals_pkg::PatLdrsWbW, 2'd3, 9'h010, 5'd3, 5'd4)));

    // Direction mismatch and words that match nothing.
    send_beat(mk_beat(mk_syn(1'b0, 1'b1, dals_pkg::DfscAfLo),
                      mk_word(dals_pkg::PatLdrWb, 2'd2, 9'h020, 5'd6, 5'd7)));
    send_beat(mk_beat(mk_syn(1'b0, 1'b0, dals_pkg::DfscAfLo),
                      mk_word(dals_pkg::PatStrPost, 2'd2, 9'h020, 5'd6, 5'd7)));
    send_beat(mk_beat(mk_syn(1'b0, 1'b0, dals_pkg::DfscAfLo), 32'd0));
    send_beat(mk_beat(mk_syn(1'b0, 1'b1, dals_pkg::DfscAfHi), '1));

    // Hold off until the directed results are all back.
    drain_results();

    for (int unsigned i = 0; i < RandBeats; i++) begin
      if (i == RandBeats / 2) drain_results();
      if (i == RandBeats - FullRate) begin
        send_idle  = 1'b0;
        recv_stall = 1'b0;
      end
      send_beat(random_abort());
    end
    s_axis_tvalid_i <= 1'b0;

    // Wait out the pipeline, then keep checking for stray beats.
    while (abort_sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (abort_sb.failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Timeout: far beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
